@@ design/amc_pkg.sv @@
// ----------------------------------------------------------------------------
// amc_pkg: shared types and constants for the millivolt converter
// Divider ratio tables, register reset values and the stage record that
// travels down the row of division cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package amc_pkg;

	// Field widths
	localparam int unsigned CH_W   = 4;
	localparam int unsigned CNT_W  = 16;
	localparam int unsigned NUM_W  = 10;
	localparam int unsigned DVS_W  = 23;
	localparam int unsigned PROD_W = 42;
	localparam int unsigned REM_W  = 39;
	localparam int unsigned QUO_W  = 16;
	localparam int unsigned SUM_W  = 43;

	localparam logic [CNT_W-1:0] FULL_SCALE = 16'd65535;

	// Register reset values
	localparam logic [CNT_W-1:0] REF_LOW_RST  = 16'd2800;
	localparam logic [CNT_W-1:0] REF_HIGH_RST = 16'd3600;
	localparam logic [CNT_W-1:0] CLIP_RST     = 16'd65472;

	// Register indexes
	typedef enum logic [1:0] {
		CFG_REF_LOW  = 2'd0,
		CFG_REF_HIGH = 2'd1,
		CFG_CLIP     = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] ref_low;
		logic [CNT_W-1:0] ref_high;
		logic [CNT_W-1:0] clip;
	} cfg_t;

	// Fields carried unchanged alongside the arithmetic
	typedef struct packed {
		logic [CH_W-1:0]  ch;
		logic [CNT_W-1:0] raw;
		logic [CNT_W-1:0] refv;
		logic             smp_ok;
	} side_t;

	// Record handed from cell to cell
	typedef struct packed {
		side_t            side;
		logic             sat;
		logic [DVS_W-1:0] dvs;
		logic [REM_W-1:0] rem;
		logic [QUO_W-1:0] quo;
	} stage_t;

	// Divider numerator per channel; channels without a ratio give zero
	function automatic logic [NUM_W-1:0] num_of(input logic [CH_W-1:0] ch);
		logic [NUM_W-1:0] n;
		case (ch)
			4'd0:    n = 10'd2;
			4'd1:    n = 10'd59;
			4'd2:    n = 10'd2;
			4'd3:    n = 10'd758;
			4'd4:    n = 10'd46;
			4'd5:    n = 10'd57;
			4'd6:    n = 10'd57;
			4'd7:    n = 10'd57;
			4'd8:    n = 10'd57;
			4'd9:    n = 10'd57;
			default: n = 10'd0;
		endcase
		return n;
	endfunction

	// Full divisor per channel: full scale times the divider denominator
	function automatic logic [DVS_W-1:0] dvs_of(input logic [CH_W-1:0] ch);
		logic [DVS_W-1:0] d;
		case (ch)
			4'd1:    d = DVS_W'(65535 * 19);
			4'd3:    d = DVS_W'(65535 * 83);
			4'd4:    d = DVS_W'(65535 * 5);
			4'd5, 4'd6, 4'd7, 4'd8, 4'd9:
			         d = DVS_W'(65535 * 10);
			default: d = DVS_W'(65535);
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

@@ design/amc_front.sv @@
// ----------------------------------------------------------------------------
// amc_front: reference check, products and rounding
// Three stages: limit checks and raw times reference, times the channel
// numerator, then the rounding offset and the saturation test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module amc_front #(
	parameter int NUM_CHANNELS = 10
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_vld,
	input  wire logic [amc_pkg::CH_W-1:0]   channel,
	input  wire logic [amc_pkg::CNT_W-1:0]  raw_count,
	input  wire logic [amc_pkg::CNT_W-1:0]  ref_mv,
	input  wire logic                       ref_fresh,
	input  wire amc_pkg::cfg_t              cfg,
	output logic                            out_vld,
	output amc_pkg::stage_t                 out_stg
);

	logic                          usable;
	logic                          ch_ok;
	logic [amc_pkg::SUM_W-1:0]     sum;
	logic                          sat;

	logic                          vld_s1, vld_s2;
	amc_pkg::side_t                side_s1, side_s2;
	logic [2*amc_pkg::CNT_W-1:0]   prod_s1;
	logic [amc_pkg::NUM_W-1:0]     num_s1;
	logic [amc_pkg::DVS_W-1:0]     dvs_s1, dvs_s2;
	logic [amc_pkg::PROD_W-1:0]    prod_s2;

	// Reference usable and channel present; a zero numerator forces zero output
	assign ch_ok  = {1'b0, channel} < (amc_pkg::CH_W+1)'(NUM_CHANNELS);
	assign usable = ref_fresh && (ref_mv >= cfg.ref_low) && (ref_mv <= cfg.ref_high) && ch_ok;

	// Rounding offset and saturation test
	assign sum = amc_pkg::SUM_W'(prod_s2) + amc_pkg::SUM_W'(dvs_s2 >> 1);
	assign sat = sum >= amc_pkg::SUM_W'({dvs_s2, 16'd0});

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			out_vld <= vld_s2;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.ch     <= channel;
			side_s1.raw    <= raw_count;
			side_s1.refv   <= ref_mv;
			side_s1.smp_ok <= usable && (raw_count < cfg.clip);
			prod_s1        <= (2*amc_pkg::CNT_W)'(raw_count) * (2*amc_pkg::CNT_W)'(ref_mv);
			num_s1         <= usable ? amc_pkg::num_of(channel) : '0;
			dvs_s1         <= amc_pkg::dvs_of(channel);

			side_s2 <= side_s1;
			prod_s2 <= amc_pkg::PROD_W'(prod_s1) * amc_pkg::PROD_W'(num_s1);
			dvs_s2  <= dvs_s1;

			out_stg.side <= side_s2;
			out_stg.sat  <= sat;
			out_stg.dvs  <= dvs_s2;
			out_stg.rem  <= sum[amc_pkg::REM_W-1:0];
			out_stg.quo  <= '0;
		end
	end

endmodule

`default_nettype wire

@@ design/amc_div_cell.sv @@
// ----------------------------------------------------------------------------
// amc_div_cell: one restoring division step
// Decides one quotient bit against the divisor shifted to this cell's
// weight and hands the reduced remainder to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module amc_div_cell #(
	parameter int unsigned BIT = 15
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_vld,
	input  wire amc_pkg::stage_t  in_stg,
	output logic                  out_vld,
	output amc_pkg::stage_t       out_stg
);

	logic [amc_pkg::REM_W-1:0] shifted;
	logic                      ge;
	amc_pkg::stage_t           nxt_stg;

	// Compare against the weighted divisor
	assign shifted = amc_pkg::REM_W'(in_stg.dvs) << BIT;
	assign ge      = in_stg.rem >= shifted;

	// Subtract and set the quotient bit
	always_comb begin
		nxt_stg     = in_stg;
		nxt_stg.rem = ge ? (in_stg.rem - shifted) : in_stg.rem;
		nxt_stg.quo = in_stg.quo | (ge ? (amc_pkg::QUO_W'(1) << BIT) : '0);
	end

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= in_vld;
		end
	end

	// Hand the record to the next cell
	always_ff @(posedge clk) begin
		if (en) begin
			out_stg <= nxt_stg;
		end
	end

endmodule

`default_nettype wire

@@ design/adc_divider_millivolt_convert.sv @@
// ----------------------------------------------------------------------------
// adc_divider_millivolt_convert: ratiometric counts to millivolts
// Converts each channel sample through its divider ratio, rounded half up.
// ----------------------------------------------------------------------------
// Takes one sample per clock while the output is not stalled and returns one
// result per sample, in order, after three front stages (limit checks and
// raw times reference, times the numerator, rounding and saturation),
// sixteen division cells that each settle one bit of the millivolt value,
// and the output register. The whole pipeline holds while a result waits
// at the output, so the input is ready whenever the output register is
// empty or being taken. Results above 65535 mV saturate; an unusable
// reference or a channel beyond NUM_CHANNELS gives 0 mV and no valid
// flag. Write the limit registers only while no sample is in flight.
`timescale 1ns / 1ps
`default_nettype none

module adc_divider_millivolt_convert #(
	parameter int NUM_CHANNELS = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// sample in
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // channel[3:0], raw_count[19:4], ref_mv[35:20]
	input  wire logic        s_tuser,   // ref_fresh
	// result out
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0] m_tdata,        // channel_out[3:0], raw_echo[19:4],
	                                    // millivolts[35:20], ref_echo[51:36]
	output logic             m_tuser,   // sample_valid
	// register writes
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [15:0] cfg_wdata
);

	localparam int unsigned NCELL = amc_pkg::QUO_W;

	amc_pkg::cfg_t   cfg_q;
	logic            en;
	logic            vld_chain [NCELL+1];
	amc_pkg::stage_t stg_chain [NCELL+1];

	logic [amc_pkg::CH_W-1:0]  ch_q;
	logic [amc_pkg::CNT_W-1:0] raw_q;
	logic [amc_pkg::CNT_W-1:0] mv_q;
	logic [amc_pkg::CNT_W-1:0] ref_q;
	logic                      smp_ok_q;
	logic                      m_tvalid_q;

	// Advance whenever the output register is free or being taken
	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = en;

	// Hold the limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ref_low  <= amc_pkg::REF_LOW_RST;
			cfg_q.ref_high <= amc_pkg::REF_HIGH_RST;
			cfg_q.clip     <= amc_pkg::CLIP_RST;
		end else if (cfg_we) begin
			case (amc_pkg::cfg_idx_t'(cfg_addr))
				amc_pkg::CFG_REF_LOW:  cfg_q.ref_low  <= cfg_wdata;
				amc_pkg::CFG_REF_HIGH: cfg_q.ref_high <= cfg_wdata;
				amc_pkg::CFG_CLIP:     cfg_q.clip     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	amc_front #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (s_tvalid),
		.channel   (s_tdata[3:0]),
		.raw_count (s_tdata[19:4]),
		.ref_mv    (s_tdata[35:20]),
		.ref_fresh (s_tuser),
		.cfg       (cfg_q),
		.out_vld   (vld_chain[0]),
		.out_stg   (stg_chain[0])
	);

	// Row of division cells, most significant quotient bit first
	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		amc_div_cell #(
			.BIT(NCELL - 1 - k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_vld  (vld_chain[k]),
			.in_stg  (stg_chain[k]),
			.out_vld (vld_chain[k+1]),
			.out_stg (stg_chain[k+1])
		);
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= vld_chain[NCELL];
		end
	end

	// Output register payload; saturate out-of-range results
	always_ff @(posedge clk) begin
		if (en) begin
			ch_q     <= stg_chain[NCELL].side.ch;
			raw_q    <= stg_chain[NCELL].side.raw;
			ref_q    <= stg_chain[NCELL].side.refv;
			smp_ok_q <= stg_chain[NCELL].side.smp_ok;
			mv_q     <= stg_chain[NCELL].sat ? amc_pkg::FULL_SCALE : stg_chain[NCELL].quo;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, ref_q, mv_q, raw_q, ch_q};
	assign m_tuser  = smp_ok_q;

	// A valid sample belongs to an existing channel
	a_valid_channel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> ({1'b0, ch_q} < (amc_pkg::CH_W+1)'(NUM_CHANNELS)))
		else $error("valid flag on a channel beyond the channel count");

	// A valid sample had its reference within the limits
	a_valid_ref: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (ref_q >= cfg_q.ref_low) && (ref_q <= cfg_q.ref_high))
		else $error("valid flag with the reference outside the limits");

	// A nonexistent channel converts to zero
	a_missing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ({1'b0, ch_q} >= (amc_pkg::CH_W+1)'(NUM_CHANNELS)) |-> (mv_q == '0))
		else $error("nonzero millivolts on a channel beyond the channel count");

	// The pipeline does not move while a result waits
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(vld_chain[NCELL]) && $stable(mv_q))
		else $error("pipeline advanced under a stalled output");

endmodule

`default_nettype wire

@@ tb/tb_adc_divider_millivolt_convert.sv @@
// ----------------------------------------------------------------------------
// tb_adc_divider_millivolt_convert: self-checking bench for the converter
// Streams channel samples through the block, predicts each result from the
// divider ratio tables and limit registers, and checks every result transfer
// in order. It runs a directed set of edge cases, then random samples under
// several limit settings and idling patterns, including one long output
// hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_adc_divider_millivolt_convert;

	localparam int NUM_CH = 10;

	typedef struct {
		logic [amc_pkg::CH_W-1:0]  ch;
		logic [amc_pkg::CNT_W-1:0] raw;
		logic [amc_pkg::CNT_W-1:0] refv;
		logic                      fresh;
	} adc_sample_t;

	typedef struct {
		logic [amc_pkg::CH_W-1:0]  ch;
		logic [amc_pkg::CNT_W-1:0] raw;
		logic [amc_pkg::CNT_W-1:0] mv;
		logic                      valid;
		logic [amc_pkg::CNT_W-1:0] refv;
	} mv_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;    // channel[3:0], raw_count[19:4], ref_mv[35:20]
	logic        s_tuser = 1'b0;  // ref_fresh
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;         // channel_out[3:0], raw_echo[19:4],
	                              // millivolts[35:20], ref_echo[51:36]
	logic        m_tuser;         // sample_valid
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = '0;
	logic [15:0] cfg_wdata = '0;

	// Divider ratio per channel; channels without a ratio convert to zero
	int unsigned ratio_num [16] = '{2, 59, 2, 758, 46, 57, 57, 57, 57, 57,
	                                0, 0, 0, 0, 0, 0};
	int unsigned ratio_den [16] = '{1, 19, 1, 83, 5, 10, 10, 10, 10, 10,
	                                1, 1, 1, 1, 1, 1};

	// Bench copy of the limit registers
	logic [amc_pkg::CNT_W-1:0] lim_lo   = amc_pkg::REF_LOW_RST;
	logic [amc_pkg::CNT_W-1:0] lim_hi   = amc_pkg::REF_HIGH_RST;
	logic [amc_pkg::CNT_W-1:0] lim_clip = amc_pkg::CLIP_RST;

	adc_sample_t sample_q[$];
	mv_result_t  mv_expect_q[$];
	adc_sample_t offered;
	int          src_idle_pct = 0;
	int          snk_stall_pct = 0;
	int          err_cnt = 0;
	logic        hold_go = 1'b0;
	int          hold_left = 0;

	adc_divider_millivolt_convert #(
		.NUM_CHANNELS(NUM_CH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Ratiometric conversion, rounded half up, saturating at full scale
	function automatic mv_result_t convert_sample(input adc_sample_t s);
		mv_result_t      r;
		longint unsigned prod;
		longint unsigned dvs;
		longint unsigned quo;
		logic            usable;
		usable = s.fresh && (s.refv >= lim_lo) && (s.refv <= lim_hi) && (s.ch < NUM_CH);
		r.ch    = s.ch;
		r.raw   = s.raw;
		r.refv  = s.refv;
		r.mv    = '0;
		r.valid = 1'b0;
		if (usable) begin
			dvs  = longint'(65535) * ratio_den[s.ch];
			prod = longint'(s.raw) * longint'(s.refv) * ratio_num[s.ch];
			quo  = (prod + dvs / 2) / dvs;
			r.mv    = (quo > 65535) ? 16'hFFFF : 16'(quo);
			r.valid = (s.raw < lim_clip);
		end
		return r;
	endfunction

	// Random sample, steered towards the current limits and clip code
	function automatic adc_sample_t rand_sample();
		adc_sample_t s;
		int          pick;
		s.ch = ($urandom_range(15) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
		pick = $urandom_range(9);
		if (pick <= 5 && lim_lo <= lim_hi)
			s.refv = 16'($urandom_range(lim_hi, lim_lo));
		else if (pick == 6)
			case ($urandom_range(3))
				0:       s.refv = lim_lo - 16'd1;
				1:       s.refv = lim_lo;
				2:       s.refv = lim_hi;
				default: s.refv = lim_hi + 16'd1;
			endcase
		else
			s.refv = 16'($urandom_range(65535));
		pick = $urandom_range(7);
		if (pick == 5)
			s.raw = lim_clip + 16'($urandom_range(2)) - 16'd1;
		else if (pick == 6)
			s.raw = $urandom_range(1) ? 16'hFFFF : 16'h0000;
		else
			s.raw = 16'($urandom_range(65535));
		s.fresh = ($urandom_range(9) != 0);
		return s;
	endfunction

	task automatic add_sample(input int ch, input int raw, input int refv, input bit fresh);
		adc_sample_t s;
		s.ch    = 4'(ch);
		s.raw   = 16'(raw);
		s.refv  = 16'(refv);
		s.fresh = fresh;
		sample_q.push_back(s);
	endtask

	task automatic add_random(input int n);
		repeat (n) sample_q.push_back(rand_sample());
	endtask

	// Write one limit register and track it in the bench copy
	task automatic write_reg(input amc_pkg::cfg_idx_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		case (idx)
			amc_pkg::CFG_REF_LOW:  lim_lo = val;
			amc_pkg::CFG_REF_HIGH: lim_hi = val;
			default:               lim_clip = val;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_limits(input logic [15:0] lo, input logic [15:0] hi,
	                          input logic [15:0] clip);
		write_reg(amc_pkg::CFG_REF_LOW, lo);
		write_reg(amc_pkg::CFG_REF_HIGH, hi);
		write_reg(amc_pkg::CFG_CLIP, clip);
	endtask

	// Hold until every sample is taken and every result has come back;
	// look just after the edge so the driver's update is already visible
	task automatic wait_drained();
		while (sample_q.size() != 0 || s_tvalid || mv_expect_q.size() != 0) begin
			@(posedge clk);
			#1;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic check_field(input string name, input int unsigned want,
	                           input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endtask

	// Sample driver: predict on each transfer, then offer the next item or idle
	always @(posedge clk) begin : sample_drive
		adc_sample_t nxt;
		if (s_tvalid && s_tready)
			mv_expect_q.push_back(convert_sample(offered));
		if (!s_tvalid || s_tready) begin
			if (arst_n && sample_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				nxt = sample_q.pop_front();
				offered  <= nxt;
				s_tvalid <= 1'b1;
				s_tdata  <= {4'b0, nxt.refv, nxt.raw, nxt.ch};
				s_tuser  <= nxt.fresh;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Long output hold-off, counted down here
	always @(posedge clk) begin
		if (hold_go)
			hold_left <= 400;
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	// Result monitor: compare each transfer with the oldest prediction
	always @(posedge clk) begin : result_check
		mv_result_t want;
		if (m_tvalid === 1'b1 && m_tready) begin
			if (mv_expect_q.size() == 0) begin
				$error("result with no sample outstanding: tdata %h tuser %b",
				       m_tdata, m_tuser);
				err_cnt++;
			end else begin
				want = mv_expect_q.pop_front();
				check_field("channel_out", want.ch, m_tdata[3:0]);
				check_field("raw_echo", want.raw, m_tdata[19:4]);
				check_field("millivolts", want.mv, m_tdata[35:20]);
				check_field("sample_valid", want.valid, m_tuser);
				check_field("ref_echo", want.refv, m_tdata[51:36]);
			end
		end
		if (hold_left > 0)
			m_tready <= 1'b0;
		else
			m_tready <= arst_n && ($urandom_range(99) >= snk_stall_pct);
	end

	// Stimulus sequence
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset limits: window edges, clip edges, stale reference, bad channels
		add_sample(0, 0, 3000, 1);
		add_sample(1, 65535, 3600, 1);
		add_sample(3, 65471, 2800, 1);
		add_sample(4, 65472, 3300, 1);
		add_sample(5, 32768, 2799, 1);
		add_sample(9, 12345, 3601, 1);
		add_sample(2, 40000, 3300, 0);
		add_sample(6, 21845, 3300, 1);
		add_sample(7, 50000, 3123, 1);
		add_sample(8, 1, 3599, 1);
		add_sample(10, 1000, 3300, 1);
		add_sample(15, 65535, 65535, 1);
		wait_drained();

		// Widest window: saturation and full-scale inputs
		set_limits(16'd0, 16'd65535, 16'd65535);
		add_sample(3, 65535, 65535, 1);
		add_sample(0, 65535, 65535, 1);
		add_sample(1, 65534, 65535, 1);
		add_sample(4, 65535, 0, 1);
		add_sample(2, 1, 1, 1);
		add_sample(9, 65535, 65535, 0);
		wait_drained();

		// Every count clipped, then an inverted window
		set_limits(16'd0, 16'd65535, 16'd0);
		add_sample(0, 0, 3300, 1);
		add_sample(3, 30000, 65535, 1);
		wait_drained();
		set_limits(16'd65535, 16'd0, 16'd65472);
		add_sample(5, 1000, 0, 1);
		add_sample(6, 1000, 65535, 1);
		wait_drained();

		// Random: reset limits, no idling
		set_limits(amc_pkg::REF_LOW_RST, amc_pkg::REF_HIGH_RST, amc_pkg::CLIP_RST);
		add_random(200);
		wait_drained();

		// Random: widest window, sender idling
		set_limits(16'd0, 16'd65535, 16'd65535);
		src_idle_pct = 46;
		add_random(250);
		wait_drained();

		// Random: mid window, receiver stalling, long hold-off to back up the pipe
		set_limits(16'd1000, 16'd5000, 16'd32768);
		src_idle_pct  = 0;
		snk_stall_pct = 46;
		add_random(250);
		@(posedge clk);
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		wait_drained();

		// Random: inverted window, both sides idling
		set_limits(16'd3000, 16'd2000, 16'd40000);
		src_idle_pct  = 26;
		snk_stall_pct = 26;
		add_random(100);
		wait_drained();

		// Random: single-point window at the top, nothing below the clip code
		set_limits(16'd65535, 16'd65535, 16'd0);
		add_random(100);
		wait_drained();

		// Random: reset limits again, cycling through the idling patterns
		set_limits(amc_pkg::REF_LOW_RST, amc_pkg::REF_HIGH_RST, amc_pkg::CLIP_RST);
		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct  = (ph == 1) ? 46 : (ph == 3) ? 26 : 0;
			snk_stall_pct = (ph == 2) ? 46 : (ph == 3) ? 26 : 0;
			add_random(90);
			wait_drained();
		end

		// Catch any stray result after the last expected one
		repeat (40) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
